// File: rtl/ifd_pkg.sv
// Shared types and constants for the IPv4 forwarding decision block.
// No dependencies; the RTL modules and the bench import this package.
`timescale 1ns / 1ps
`default_nettype none

package ifd_pkg;

  localparam int unsigned IFACE_NUM = 4;

  // header fields we check against
  localparam logic [3:0]  IP_VERSION   = 4'd4;
  localparam logic [3:0]  IP_IHL       = 4'd5;
  localparam logic [16:0] ETH_HDR_LEN  = 17'd14;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [15:0] CKSUM_GOOD   = 16'hFFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_IFACE_ADDR0 = 3'd0,
    CFG_IFACE_ADDR1 = 3'd1,
    CFG_IFACE_ADDR2 = 3'd2,
    CFG_IFACE_ADDR3 = 3'd3,
    CFG_IFACE_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_DROP       = 3'd0,
    ACT_FORWARD    = 3'd1,
    ACT_ECHO_REPLY = 3'd2,
    ACT_TIME_EXCD  = 3'd3,
    ACT_PORT_UNRCH = 3'd4,
    ACT_NET_UNRCH  = 3'd5
  } act_t;

  typedef logic [IFACE_NUM-1:0][31:0] iface_vec_t;

  // one route table word
  typedef struct packed {
    logic        vld;
    logic [1:0]  port;
    logic [31:0] mask;
    logic [31:0] prefix;
  } route_ent_t;

  // header check result
  typedef struct packed {
    logic        ok;
    logic        for_us;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] ncks;
    logic [31:0] dst;
  } hdr_res_t;

  // route lookup result
  typedef struct packed {
    logic       hit;
    logic [1:0] port;
  } lpm_res_t;

endpackage

`default_nettype wire

// File: rtl/ifd_ifs.sv
// Request and result channel interfaces (valid/ready plus payload).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ifd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] hdr_word0;
  logic [31:0] hdr_word1;
  logic [31:0] hdr_word2;
  logic [31:0] hdr_word3;
  logic [31:0] hdr_word4;
  logic [15:0] frame_length;
  logic [1:0]  ingress_port;
  logic [3:0]  route_slot;
  logic [31:0] route_prefix;
  logic [31:0] route_netmask;
  logic [1:0]  route_port;

  modport source (
    output valid, mode, hdr_word0, hdr_word1, hdr_word2, hdr_word3, hdr_word4,
           frame_length, ingress_port, route_slot, route_prefix, route_netmask,
           route_port,
    input  ready
  );
  modport sink (
    input  valid, mode, hdr_word0, hdr_word1, hdr_word2, hdr_word3, hdr_word4,
           frame_length, ingress_port, route_slot, route_prefix, route_netmask,
           route_port,
    output ready
  );
endinterface

interface ifd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  egress_port;
  logic [7:0]  new_ttl;
  logic [15:0] new_checksum;

  modport source (
    output valid, action, egress_port, new_ttl, new_checksum,
    input  ready
  );
  modport sink (
    input  valid, action, egress_port, new_ttl, new_checksum,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/ifd_route_mem.sv
// Route table memory: one write port, one read port, registered read data.
// Depends on ifd_pkg (route_ent_t).
`timescale 1ns / 1ps
`default_nettype none

module ifd_route_mem import ifd_pkg::*; #(
  parameter int unsigned ROUTE_ENTRIES = 16,
  parameter int unsigned AW            = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire route_ent_t    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output route_ent_t         rd_data
);

  route_ent_t mem_r [ROUTE_ENTRIES];
  route_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/ifd_hdr_chk.sv
// Two-stage IPv4 header check: format, length, checksum, local address match,
// and the rewritten checksum for a decremented TTL. Depends on ifd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifd_hdr_chk import ifd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start_i,
  input  wire logic [31:0] w0_i,
  input  wire logic [31:0] w1_i,
  input  wire logic [31:0] w2_i,
  input  wire logic [31:0] w3_i,
  input  wire logic [31:0] w4_i,
  input  wire logic [15:0] flen_i,
  input  wire iface_vec_t  iface_addr_i,
  input  wire logic [2:0]  iface_cnt_i,
  output logic             done_o,
  output hdr_res_t         res_o
);

  // ones'-complement end-around fold, two passes
  function automatic logic [15:0] fold16(input logic [19:0] s);
    logic [16:0] f1;
    f1 = 17'(s[15:0]) + 17'(s[19:16]);
    return f1[15:0] + 16'(f1[16]);
  endfunction

  logic        s1_vld_r;
  logic [18:0] base_r;    // w0, w1, w3, w4 halfwords
  logic [31:0] w2_r;
  logic [31:0] dst_r;
  logic        fmt_ok_r;
  logic        for_us_r;
  logic        s2_vld_r;
  hdr_res_t    res_r;

  logic [18:0] base_nxt;
  logic        fmt_ok_nxt;
  logic        for_us_nxt;
  logic [19:0] sum_old;
  logic [19:0] sum_new;
  logic [7:0]  ttl_dec;

  always_comb begin
    base_nxt = 19'(w0_i[31:16]) + 19'(w0_i[15:0]) + 19'(w1_i[31:16]) + 19'(w1_i[15:0])
             + 19'(w3_i[31:16]) + 19'(w3_i[15:0]) + 19'(w4_i[31:16]) + 19'(w4_i[15:0]);
    fmt_ok_nxt = (w0_i[31:28] == IP_VERSION) && (w0_i[27:24] == IP_IHL) &&
                 ({1'b0, flen_i} == ({1'b0, w0_i[15:0]} + ETH_HDR_LEN));
    for_us_nxt = 1'b0;
    for (int k = 0; k < IFACE_NUM; k++) begin
      if ((iface_cnt_i > 3'(k)) && (iface_addr_i[k] == w4_i)) begin
        for_us_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    ttl_dec = w2_r[31:24] - 8'd1;
    sum_old = 20'(base_r) + 20'(w2_r[31:16]) + 20'(w2_r[15:0]);
    sum_new = 20'(base_r) + 20'({ttl_dec, w2_r[23:16]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start_i;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      base_r   <= base_nxt;
      w2_r     <= w2_i;
      dst_r    <= w4_i;
      fmt_ok_r <= fmt_ok_nxt;
      for_us_r <= for_us_nxt;
    end
    if (s1_vld_r) begin
      res_r.ok     <= fmt_ok_r && (fold16(sum_old) == CKSUM_GOOD);
      res_r.for_us <= for_us_r;
      res_r.ttl    <= w2_r[31:24];
      res_r.proto  <= w2_r[23:16];
      res_r.ncks   <= ~fold16(sum_new);
      res_r.dst    <= dst_r;
    end
  end

  assign done_o = s2_vld_r;
  assign res_o  = res_r;

endmodule

`default_nettype wire

// File: rtl/ifd_lpm_scan.sv
// Longest-prefix scan: walks the route memory one entry per cycle through a
// read / match / compare pipeline, ties to the lowest index. Depends on ifd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifd_lpm_scan import ifd_pkg::*; #(
  parameter int unsigned ROUTE_ENTRIES = 16,
  parameter int unsigned AW            = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start_i,
  input  wire logic [31:0]   dst_i,
  output logic     [AW-1:0]  rd_addr_o,
  input  wire route_ent_t    rd_data_i,
  output logic               done_o,
  output lpm_res_t           res_o
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(ROUTE_ENTRIES - 1);

  // population count, one byte at a time
  function automatic logic [5:0] ones32(input logic [31:0] v);
    logic [3:0] b [4];
    for (int k = 0; k < 4; k++) begin
      b[k] = '0;
      for (int j = 0; j < 8; j++) begin
        b[k] = b[k] + 4'(v[8*k+j]);
      end
    end
    return 6'(b[0]) + 6'(b[1]) + 6'(b[2]) + 6'(b[3]);
  endfunction

  logic          issue_r;
  logic          drain_r;
  logic [AW-1:0] addr_r;
  logic          rd_vld_r;
  logic [31:0]   dst_r;
  logic          m_vld_r;
  logic          m_hit_r;
  logic [5:0]    m_len_r;
  logic [1:0]    m_port_r;
  logic          best_hit_r;
  logic [5:0]    best_len_r;
  logic [1:0]    best_port_r;

  logic done;

  assign done = drain_r && !rd_vld_r && !m_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r  <= 1'b0;
      drain_r  <= 1'b0;
      rd_vld_r <= 1'b0;
      m_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= issue_r;
      m_vld_r  <= rd_vld_r;
      if (start_i) begin
        issue_r <= 1'b1;
      end else if (issue_r && (addr_r == LAST_ADDR)) begin
        issue_r <= 1'b0;
        drain_r <= 1'b1;
      end else if (done) begin
        drain_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      addr_r <= '0;
      dst_r  <= dst_i;
    end else if (issue_r) begin
      addr_r <= addr_r + AW'(1);
    end
    // match stage
    m_hit_r  <= rd_data_i.vld && (((rd_data_i.prefix ^ dst_r) & rd_data_i.mask) == '0);
    m_len_r  <= ones32(rd_data_i.mask);
    m_port_r <= rd_data_i.port;
    // best-so-far; strict compare keeps the lowest index on a tie
    if (start_i) begin
      best_hit_r <= 1'b0;
      best_len_r <= '0;
    end else if (m_vld_r && m_hit_r && (!best_hit_r || (m_len_r > best_len_r))) begin
      best_hit_r  <= 1'b1;
      best_len_r  <= m_len_r;
      best_port_r <= m_port_r;
    end
  end

  assign rd_addr_o = addr_r;
  assign done_o    = done;
  assign res_o.hit  = best_hit_r;
  assign res_o.port = best_port_r;

endmodule

`default_nettype wire

// File: rtl/ipv4_forward_decision.sv
// Top level of the IPv4 forwarding decision block: config registers, control
// sequencer, route write path and result register.
// Depends on ifd_pkg, ifd_ifs, ifd_route_mem, ifd_hdr_chk, ifd_lpm_scan.
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake          carries
//  in_ch     in   valid/ready        mode, header words, frame length, ports,
//                                    route slot/prefix/netmask/port
//  out_ch    out  valid/ready        action, egress_port, new_ttl, new_checksum
//  cfg_*     in   cfg_we (no stall)  interface addresses, interface count
//
//  Route write request (mode 1): writes the memory when accepted, no result.
//  Classify request (mode 0): accept, header check, then a table scan (one
//  memory read per entry plus pipeline drain) and a hand-off to the output
//  register once it is free or being drained. Drops and local replies skip
//  the scan. After reset the table is swept clear before the first request
//  is taken; config writes are accepted throughout.
//  One request in flight at a time; a finished result waits in the output
//  register, and a new request is taken while it waits.

module ipv4_forward_decision import ifd_pkg::*; #(
  parameter int unsigned ROUTE_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ifd_in_if.sink           in_ch,
  ifd_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [31:0] cfg_wdata
);

  localparam int unsigned AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ROUTE_ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // ---------------- configuration registers ----------------
  iface_vec_t  iface_addr_r;
  logic [2:0]  iface_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_addr_r <= '0;
      iface_cnt_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IFACE_ADDR0: iface_addr_r[0] <= cfg_wdata;
        CFG_IFACE_ADDR1: iface_addr_r[1] <= cfg_wdata;
        CFG_IFACE_ADDR2: iface_addr_r[2] <= cfg_wdata;
        CFG_IFACE_ADDR3: iface_addr_r[3] <= cfg_wdata;
        CFG_IFACE_COUNT: iface_cnt_r     <= cfg_wdata[2:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // ---------------- sequencer state ----------------
  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [1:0]    inport_r, inport_nxt;

  // pending result, then the output register
  act_t          act_r, act_nxt;
  logic [1:0]    eport_r, eport_nxt;
  logic [7:0]    nttl_r, nttl_nxt;
  logic [15:0]   ncks_r, ncks_nxt;

  logic          out_vld_r, out_vld_nxt;
  act_t          out_act_r;
  logic [1:0]    out_eport_r;
  logic [7:0]    out_ttl_r;
  logic [15:0]   out_cks_r;

  logic          in_acc;
  logic          out_load;
  logic          scan_start;

  // memory ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  route_ent_t    wr_data;
  logic [AW-1:0] rd_addr;
  route_ent_t    rd_data;

  logic          hdr_done;
  hdr_res_t      hdr_res;
  logic          lpm_done;
  lpm_res_t      lpm_res;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // ---------------- datapath units ----------------
  ifd_route_mem #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .AW           (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ifd_hdr_chk u_hdr (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_acc && !in_ch.mode),
    .w0_i        (in_ch.hdr_word0),
    .w1_i        (in_ch.hdr_word1),
    .w2_i        (in_ch.hdr_word2),
    .w3_i        (in_ch.hdr_word3),
    .w4_i        (in_ch.hdr_word4),
    .flen_i      (in_ch.frame_length),
    .iface_addr_i(iface_addr_r),
    .iface_cnt_i (iface_cnt_r),
    .done_o      (hdr_done),
    .res_o       (hdr_res)
  );

  ifd_lpm_scan #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .AW           (AW)
  ) u_lpm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (scan_start),
    .dst_i    (hdr_res.dst),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .done_o   (lpm_done),
    .res_o    (lpm_res)
  );

  // ---------------- memory write path ----------------
  // Clear sweep after reset, otherwise route writes. Slots past the table
  // are dropped. No scan runs while a write can happen.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
    end else begin
      wr_addr        = AW'(in_ch.route_slot);
      wr_data.vld    = 1'b1;
      wr_data.port   = in_ch.route_port;
      wr_data.mask   = in_ch.route_netmask;
      wr_data.prefix = in_ch.route_prefix;
      wr_en = in_acc && in_ch.mode && ({28'd0, in_ch.route_slot} < 32'(ROUTE_ENTRIES));
    end
  end

  // ---------------- decision sequencer ----------------
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    inport_nxt   = inport_r;
    act_nxt      = act_r;
    eport_nxt    = eport_r;
    nttl_nxt     = nttl_r;
    ncks_nxt     = ncks_r;
    scan_start   = 1'b0;
    out_load     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && !in_ch.mode) begin
          inport_nxt = in_ch.ingress_port;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (hdr_done) begin
          nttl_nxt  = '0;
          ncks_nxt  = '0;
          eport_nxt = inport_r;
          state_nxt = ST_DONE;
          if (!hdr_res.ok) begin
            act_nxt   = ACT_DROP;
            eport_nxt = '0;
          end else if (hdr_res.for_us) begin
            if (hdr_res.ttl == 8'd0) begin
              act_nxt = ACT_TIME_EXCD;
            end else if (hdr_res.proto == PROTO_ICMP) begin
              act_nxt = ACT_ECHO_REPLY;
            end else begin
              act_nxt = ACT_PORT_UNRCH;
            end
          end else if (hdr_res.ttl <= 8'd1) begin
            act_nxt = ACT_TIME_EXCD;
          end else begin
            scan_start = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (lpm_done) begin
          state_nxt = ST_DONE;
          if (lpm_res.hit) begin
            act_nxt   = ACT_FORWARD;
            eport_nxt = lpm_res.port;
            nttl_nxt  = hdr_res.ttl - 8'd1;
            ncks_nxt  = hdr_res.ncks;
          end else begin
            act_nxt   = ACT_NET_UNRCH;
            eport_nxt = inport_r;
          end
        end
      end
      ST_DONE: begin
        // hand off once the output register is free or being drained
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inport_r <= inport_nxt;
    act_r    <= act_nxt;
    eport_r  <= eport_nxt;
    nttl_r   <= nttl_nxt;
    ncks_r   <= ncks_nxt;
    if (out_load) begin
      out_act_r   <= act_r;
      out_eport_r <= eport_r;
      out_ttl_r   <= nttl_r;
      out_cks_r   <= ncks_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.action       = out_act_r;
  assign out_ch.egress_port  = out_eport_r;
  assign out_ch.new_ttl      = out_ttl_r;
  assign out_ch.new_checksum = out_cks_r;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking bench for ipv4_forward_decision: sends route writes and header
// classify requests, predicts each decision in-bench and compares every result.
// Depends on rtl/ifd_pkg.sv, rtl/ifd_ifs.sv and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import ifd_pkg::*;

  localparam int unsigned ROUTES       = 16;
  localparam int unsigned DRAIN_CYCLES = 40;      // settle time after the longest lookup
  localparam int unsigned HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT  = 600000;

  // one request on the input channel; hdr[0] is header word 0
  typedef struct packed {
    logic             mode;
    logic [4:0][31:0] hdr;
    logic [15:0]      frame_length;
    logic [1:0]       ingress_port;
    logic [3:0]       route_slot;
    logic [31:0]      route_prefix;
    logic [31:0]      route_netmask;
    logic [1:0]       route_port;
  } request_t;

  typedef struct packed {
    act_t        action;
    logic [1:0]  egress_port;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } decision_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;
  logic [31:0] cfg_wdata;

  ifd_in_if  in_ch ();
  ifd_out_if out_ch ();

  ipv4_forward_decision #(.ROUTE_ENTRIES(ROUTES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // bench copy of the block's state
  logic [31:0] if_addr [IFACE_NUM];
  logic [2:0]  if_count;
  logic [31:0] route_prefix_tbl [ROUTES];
  logic [31:0] route_mask_tbl   [ROUTES];
  logic [1:0]  route_port_tbl   [ROUTES];
  bit          route_used_tbl   [ROUTES];

  decision_t   pending_decisions [$];
  int unsigned error_count;
  int unsigned cycle_count;

  // idle / stall control
  bit sender_idles;
  bit receiver_idles;
  bit hold_request;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // end-around-carry sum of the ten header halfwords
  function automatic logic [15:0] ones_sum(input logic [4:0][31:0] w);
    int unsigned s;
    s = 0;
    for (int k = 0; k < 5; k++) s += w[k][31:16] + w[k][15:0];
    s = (s & 32'hFFFF) + (s >> 16);
    s = (s & 32'hFFFF) + (s >> 16);
    return s[15:0];
  endfunction

  function automatic decision_t predict_decision(input request_t r);
    decision_t        d;
    logic [4:0][31:0] fwd_hdr;
    logic [7:0]       ttl;
    logic [7:0]       proto;
    logic [31:0]      dst;
    int unsigned      active;
    int unsigned      best_len;
    int unsigned      best;
    bit               hdr_ok;
    bit               for_us;
    bit               hit;
    d        = '0;
    d.action = ACT_DROP;
    ttl      = r.hdr[2][31:24];
    proto    = r.hdr[2][23:16];
    dst      = r.hdr[4];
    // 17-bit compare: total length near 0xFFFF can never match
    hdr_ok = r.hdr[0][31:28] == IP_VERSION && r.hdr[0][27:24] == IP_IHL &&
             {1'b0, r.frame_length} == ({1'b0, r.hdr[0][15:0]} + 17'd14) &&
             ones_sum(r.hdr) == CKSUM_GOOD;
    if (!hdr_ok) return d;

    active = (if_count > IFACE_NUM) ? IFACE_NUM : if_count;
    for_us = 1'b0;
    for (int k = 0; k < IFACE_NUM; k++)
      if (k < active && if_addr[k] == dst) for_us = 1'b1;

    d.egress_port = r.ingress_port;
    if (for_us) begin
      if (ttl == 8'd0) d.action = ACT_TIME_EXCD;
      else if (proto == PROTO_ICMP) d.action = ACT_ECHO_REPLY;
      else d.action = ACT_PORT_UNRCH;
    end else if (ttl <= 8'd1) begin
      d.action = ACT_TIME_EXCD;
    end else begin
      // longest mask wins, ties stay with the lower slot
      hit      = 1'b0;
      best_len = 0;
      best     = 0;
      for (int k = 0; k < ROUTES; k++) begin
        if (route_used_tbl[k] &&
            (route_prefix_tbl[k] & route_mask_tbl[k]) == (dst & route_mask_tbl[k])) begin
          if (!hit || $countones(route_mask_tbl[k]) > best_len) begin
            hit      = 1'b1;
            best_len = $countones(route_mask_tbl[k]);
            best     = k;
          end
        end
      end
      if (hit) begin
        d.action      = ACT_FORWARD;
        d.egress_port = route_port_tbl[best];
        d.new_ttl     = ttl - 8'd1;
        fwd_hdr       = r.hdr;
        fwd_hdr[2]    = {d.new_ttl, proto, 16'h0000};
        d.new_checksum = ~ones_sum(fwd_hdr);
      end else begin
        d.action = ACT_NET_UNRCH;
      end
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  function automatic request_t seal_header(input request_t r);
    r.hdr[2][15:0] = 16'h0000;
    r.hdr[2][15:0] = ~ones_sum(r.hdr);
    return r;
  endfunction

  function automatic logic [31:0] mask_of_len(input int unsigned len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // well-formed header with a good checksum; route fields are noise
  function automatic request_t build_packet(input logic [31:0] dst, input logic [7:0] ttl,
                                            input logic [7:0] proto, input logic [1:0] port);
    request_t    r;
    logic [15:0] totlen;
    if ($urandom_range(0, 1) == 0) totlen = 16'($urandom_range(20, 1500));
    else totlen = 16'($urandom_range(0, 65521));
    r.mode          = 1'b0;
    r.hdr[0]        = {IP_VERSION, IP_IHL, 8'($urandom), totlen};
    r.hdr[1]        = $urandom;
    r.hdr[2]        = {ttl, proto, 16'h0000};
    r.hdr[3]        = $urandom;
    r.hdr[4]        = dst;
    r.frame_length  = totlen + 16'd14;
    r.ingress_port  = port;
    r.route_slot    = 4'($urandom);
    r.route_prefix  = $urandom;
    r.route_netmask = $urandom;
    r.route_port    = 2'($urandom);
    return seal_header(r);
  endfunction

  // route table write; header fields are noise
  function automatic request_t build_route(input logic [3:0] slot, input logic [31:0] prefix,
                                           input logic [31:0] mask, input logic [1:0] port);
    request_t r;
    r.mode          = 1'b1;
    r.hdr           = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r.frame_length  = 16'($urandom);
    r.ingress_port  = 2'($urandom);
    r.route_slot    = slot;
    r.route_prefix  = prefix;
    r.route_netmask = mask;
    r.route_port    = port;
    return r;
  endfunction

  function automatic request_t rand_route_write();
    logic [31:0] mask;
    int unsigned len;
    if ($urandom_range(0, 3) == 0) begin
      mask = $urandom;                  // non-contiguous
    end else begin
      len  = ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 32);
      mask = mask_of_len(len);
    end
    return build_route(4'($urandom), $urandom, mask, 2'($urandom));
  endfunction

  function automatic request_t rand_packet();
    request_t    r;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      dst = if_addr[$urandom_range(0, IFACE_NUM - 1)];
    end else if (pick < 70) begin
      // land inside some table entry, random host bits
      k   = $urandom_range(0, ROUTES - 1);
      dst = (route_prefix_tbl[k] & route_mask_tbl[k]) | ($urandom & ~route_mask_tbl[k]);
    end else begin
      dst = $urandom;
    end
    case ($urandom_range(0, 5))
      0:       ttl = 8'd0;
      1:       ttl = 8'd1;
      2:       ttl = 8'd2;
      3:       ttl = 8'd255;
      default: ttl = 8'($urandom);
    endcase
    proto = ($urandom_range(0, 1) == 0) ? PROTO_ICMP : 8'($urandom);
    r = build_packet(dst, ttl, proto, 2'($urandom));

    // about one in five gets broken
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 6))
        0: begin
          r.hdr[0][31:28] = 4'($urandom);
          r = seal_header(r);
        end
        1: begin
          r.hdr[0][27:24] = 4'($urandom);
          r = seal_header(r);
        end
        2: r.frame_length = 16'($urandom);
        3: r.frame_length = 16'($urandom_range(0, 13));
        4: r.hdr[2][$urandom_range(0, 15)] ^= 1'b1;
        5: begin
          r.hdr          = {$urandom, $urandom, $urandom, $urandom, $urandom};
          r.frame_length = 16'($urandom);
        end
        default: begin
          r.hdr[0][15:0] = 16'($urandom_range(65522, 65535));
          r.frame_length = 16'hFFFF;
          r = seal_header(r);
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until taken, then update the bench state.
  task automatic send_request(input request_t r);
    int unsigned gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= r.mode;
    in_ch.hdr_word0     <= r.hdr[0];
    in_ch.hdr_word1     <= r.hdr[1];
    in_ch.hdr_word2     <= r.hdr[2];
    in_ch.hdr_word3     <= r.hdr[3];
    in_ch.hdr_word4     <= r.hdr[4];
    in_ch.frame_length  <= r.frame_length;
    in_ch.ingress_port  <= r.ingress_port;
    in_ch.route_slot    <= r.route_slot;
    in_ch.route_prefix  <= r.route_prefix;
    in_ch.route_netmask <= r.route_netmask;
    in_ch.route_port    <= r.route_port;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    // block handles one request at a time, in order
    if (r.mode) begin
      route_prefix_tbl[r.route_slot] = r.route_prefix;
      route_mask_tbl[r.route_slot]   = r.route_netmask;
      route_port_tbl[r.route_slot]   = r.route_port;
      route_used_tbl[r.route_slot]   = 1'b1;
    end else begin
      pending_decisions.push_back(predict_decision(r));
    end
  endtask

  // Drop valid, wait out every pending decision, then let a trailing route
  // write or scan settle before touching the registers.
  task automatic wait_for_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_IFACE_COUNT) if_count = value[2:0];
    else if_addr[idx[1:0]] = value;
  endtask

  // all five registers, upper bits of the count word are junk
  task automatic set_interfaces(input logic [31:0] a0, input logic [31:0] a1,
                                input logic [31:0] a2, input logic [31:0] a3,
                                input logic [2:0] count);
    logic [31:0] count_word;
    count_word      = $urandom;
    count_word[2:0] = count;
    write_register(CFG_IFACE_ADDR0, a0);
    write_register(CFG_IFACE_ADDR1, a1);
    write_register(CFG_IFACE_ADDR2, a2);
    write_register(CFG_IFACE_ADDR3, a3);
    write_register(CFG_IFACE_COUNT, count_word);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_request(rand_route_write());
      else send_request(rand_packet());
    end
  endtask

  // Result side: random stall bursts, or one long hold-off when asked.
  initial begin : result_ready_driver
    int unsigned burst;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result against the oldest pending decision.
  always @(posedge clk) begin : result_checker
    decision_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: action %0d egress %0d ttl %0d cksum %h",
                   out_ch.action, out_ch.egress_port, out_ch.new_ttl, out_ch.new_checksum);
      end else begin
        want = pending_decisions.pop_front();
        if (out_ch.action !== want.action || out_ch.egress_port !== want.egress_port ||
            out_ch.new_ttl !== want.new_ttl || out_ch.new_checksum !== want.new_checksum) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch exp/act: action %0d/%0d egress %0d/%0d ttl %0d/%0d cksum %h/%h",
                     want.action, out_ch.action, want.egress_port, out_ch.egress_port,
                     want.new_ttl, out_ch.new_ttl, want.new_checksum, out_ch.new_checksum);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each header check on its own: version, IHL, length, short frame, checksum,
  // and a total length so large that adding the ethernet header overflows.
  task automatic test_header_checks();
    request_t r;
    r = build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd0);
    r.hdr[0][31:28] = 4'd6;
    send_request(seal_header(r));
    r = build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd1);
    r.hdr[0][27:24] = 4'd15;
    send_request(seal_header(r));
    r = build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd2);
    r.frame_length = r.frame_length + 16'd1;
    send_request(r);
    r = build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd3);
    r.frame_length = 16'd0;
    send_request(r);
    r = build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd0);
    r.hdr[2][0] ^= 1'b1;
    send_request(r);
    r = build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd1);
    r.hdr[0][15:0] = 16'hFFFF;
    r.frame_length = 16'hFFFF;
    send_request(seal_header(r));
  endtask

  // Packets addressed to the router: TTL 0, ping, other protocol, TTL 1 ping.
  task automatic test_local_delivery();
    send_request(build_packet(32'h0A00_0001, 8'd0, PROTO_ICMP, 2'd0));
    send_request(build_packet(32'hC0A8_0101, 8'd64, PROTO_ICMP, 2'd1));
    send_request(build_packet(32'hFFFF_FFFF, 8'd255, 8'd17, 2'd3));
    send_request(build_packet(32'h0000_0000, 8'd1, PROTO_ICMP, 2'd2));
  endtask

  // Empty-table miss, longest prefix, equal-length tie, TTL limits,
  // non-contiguous mask and a default route.
  task automatic test_route_lookup();
    send_request(build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd1));
    send_request(build_route(4'd0,  32'h0A00_0000, mask_of_len(8),  2'd1));
    send_request(build_route(4'd15, 32'h0A01_0000, mask_of_len(16), 2'd2));
    send_request(build_route(4'd3,  32'h0A01_FFFF, mask_of_len(16), 2'd3));
    send_request(build_route(4'd8,  32'hAB00_CD00, 32'hFF00_FF00,   2'd0));
    send_request(build_packet(32'h0A01_0203, 8'd64, 8'd6, 2'd0));
    send_request(build_packet(32'h0A09_0909, 8'd255, 8'd17, 2'd2));
    send_request(build_packet(32'h0A01_0000, 8'd1, 8'd6, 2'd3));
    send_request(build_packet(32'h0A01_0000, 8'd0, 8'd6, 2'd0));
    send_request(build_packet(32'h0A01_0000, 8'd2, 8'd6, 2'd1));
    send_request(build_packet(32'hAB12_CD34, 8'd9, 8'd6, 2'd2));
    send_request(build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd3));
    send_request(build_route(4'd5, 32'hFFFF_FFFF, mask_of_len(0), 2'd2));
    send_request(build_packet(32'h0B00_0001, 8'd64, 8'd6, 2'd0));
  endtask

  // Random traffic under several interface settings, counts 0 and above 4 too.
  task automatic test_interface_counts();
    wait_for_idle();
    set_interfaces($urandom, $urandom, $urandom, $urandom, 3'd4);
    run_traffic(220);
    wait_for_idle();
    set_interfaces($urandom, $urandom, $urandom, $urandom, 3'd0);
    run_traffic(220);
    wait_for_idle();
    set_interfaces(32'h0, 32'hFFFF_FFFF, $urandom, $urandom, 3'd7);
    run_traffic(220);
    wait_for_idle();
    set_interfaces($urandom, $urandom, 32'h0, 32'hFFFF_FFFF, 3'd2);
    run_traffic(220);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // output register and the in-flight slot fill and in_ch.ready drops.
  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_request = 1'b1;
    run_traffic(30);
    sender_idles = 1'b1;
  endtask

  // Back-to-back requests with results drained at full rate.
  task automatic test_steady_stream();
    wait_for_idle();
    set_interfaces(32'hFFFF_FFFF, $urandom, $urandom, 32'h0, 3'd5);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_traffic(180);
  endtask

  initial begin : run
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_IFACE_ADDR0;
    cfg_wdata           = 32'h0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = 1'b0;
    in_ch.hdr_word0     = 32'h0;
    in_ch.hdr_word1     = 32'h0;
    in_ch.hdr_word2     = 32'h0;
    in_ch.hdr_word3     = 32'h0;
    in_ch.hdr_word4     = 32'h0;
    in_ch.frame_length  = 16'h0;
    in_ch.ingress_port  = 2'd0;
    in_ch.route_slot    = 4'd0;
    in_ch.route_prefix  = 32'h0;
    in_ch.route_netmask = 32'h0;
    in_ch.route_port    = 2'd0;
    sender_idles        = 1'b1;
    receiver_idles      = 1'b1;
    hold_request        = 1'b0;
    error_count         = 0;
    cycle_count         = 0;
    if_count            = 3'd0;
    for (int k = 0; k < IFACE_NUM; k++) if_addr[k] = 32'h0;
    for (int k = 0; k < ROUTES; k++) begin
      route_prefix_tbl[k] = 32'h0;
      route_mask_tbl[k]   = 32'h0;
      route_port_tbl[k]   = 2'd0;
      route_used_tbl[k]   = 1'b0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // config is open during the post-reset table sweep
    set_interfaces(32'h0A00_0001, 32'hC0A8_0101, 32'h0, 32'hFFFF_FFFF, 3'd4);

    test_header_checks();
    test_local_delivery();
    test_route_lookup();
    test_interface_counts();
    test_backpressure();
    test_steady_stream();

    wait_for_idle();
    if (error_count == 0 && pending_decisions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ifd_pkg.sv
rtl/ifd_ifs.sv
rtl/ifd_route_mem.sv
rtl/ifd_hdr_chk.sv
rtl/ifd_lpm_scan.sv
rtl/ipv4_forward_decision.sv
dv/testbench.sv
